// ===== design/irc_pkg.sv =====
package irc_pkg;

    // number format
    localparam int DIGIT_COUNT = 10;
    localparam int DIG_W       = 4;
    localparam int ACC_W       = 40;
    localparam int BASE_W      = 5;
    localparam int CNT_W       = $clog2(DIGIT_COUNT);
    localparam int BIT_CNT_W   = $clog2(ACC_W);
    localparam int TDATA_W     = 8;

    // fixed base and base limits
    localparam logic [BASE_W-1:0] DEC_BASE = BASE_W'(10);
    localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(16);

    // configuration register indexes
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_RADIX     = 1'b1;

    // one finished number handed from the front to the back
    typedef struct packed {
        logic [ACC_W-1:0]  value;
        logic [BASE_W-1:0] base;
    } t_conv_req;

    // back end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

endpackage

// ===== design/irc_front.sv =====
module irc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [4:0]             i_cfg_wdata,
    input  logic                   i_s_tvalid,
    input  logic [3:0]             i_s_tdata,
    output logic                   o_s_tready,
    input  logic                   i_full,
    output logic                   o_push,
    output irc_pkg::t_conv_req     o_req
);
    import irc_pkg::*;

    logic              r_direction;
    logic [BASE_W-1:0] r_radix;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] in_base;
    logic [BASE_W-1:0] out_base;
    logic [ACC_W+BASE_W-1:0] prod;
    logic [ACC_W-1:0]  horner;
    logic              last_in;
    logic              accept;

    // clamp the configured base into its legal range
    always_comb begin
        if (r_radix < MIN_BASE) begin
            base = MIN_BASE;
        end else if (r_radix > MAX_BASE) begin
            base = MAX_BASE;
        end else begin
            base = r_radix;
        end
        in_base  = r_direction ? DEC_BASE : base;
        out_base = r_direction ? base : DEC_BASE;
    end

    // horner step: acc * base + digit
    assign prod    = {{BASE_W{1'b0}}, r_acc} * {{ACC_W{1'b0}}, in_base};
    assign horner  = prod[ACC_W-1:0] + {{(ACC_W-DIG_W){1'b0}}, i_s_tdata};
    assign last_in = (r_cnt == CNT_W'(DIGIT_COUNT - 1));

    // a last digit waits for room in the queue
    assign o_s_tready = !last_in || !i_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = accept && last_in;
    assign o_req      = '{value: horner, base: out_base};

    // next accumulator and digit count
    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (accept) begin
            if (last_in) begin
                n_acc = '0;
                n_cnt = '0;
            end else begin
                n_acc = horner;
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    // configuration and accumulator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_radix     <= MIN_BASE;
            r_acc       <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_DIRECTION) begin
                r_direction <= i_cfg_wdata[0];
            end
            if (i_cfg_we && i_cfg_index == REG_RADIX) begin
                r_radix <= i_cfg_wdata;
            end
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== design/irc_queue.sv =====
module irc_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  irc_pkg::t_conv_req     i_req,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_empty,
    output irc_pkg::t_conv_req     o_req
);
    import irc_pkg::*;

    // two-entry queue of finished numbers
    t_conv_req  r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_req   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== design/irc_back.sv =====
module irc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  irc_pkg::t_conv_req     i_req,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,
    output logic                   o_m_tlast,
    output logic                   o_m_tuser
);
    import irc_pkg::*;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [ACC_W-1:0]     r_quo;
    logic [ACC_W-1:0]     n_quo;
    logic [DIG_W-1:0]     r_rem;
    logic [DIG_W-1:0]     n_rem;
    logic [BASE_W-1:0]    r_div;
    logic [BASE_W-1:0]    n_div;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [BIT_CNT_W-1:0] n_bit;
    logic [CNT_W-1:0]     r_dcnt;
    logic [CNT_W-1:0]     n_dcnt;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     n_idx;
    logic                 r_ovf;
    logic                 n_ovf;
    logic [DIG_W-1:0]     r_digs [DIGIT_COUNT];
    logic [BASE_W-1:0]    rem_sh;
    logic                 ge;
    logic [BASE_W-1:0]    rem_sub;
    logic [DIG_W-1:0]     rem_nx;
    logic [ACC_W-1:0]     quo_nx;
    logic                 bit_done;
    logic                 div_done;
    logic                 emit_take;
    logic                 emit_done;

    // one restoring division step per cycle
    assign rem_sh   = {r_rem, r_quo[ACC_W-1]};
    assign ge       = (rem_sh >= r_div);
    assign rem_sub  = rem_sh - r_div;
    assign rem_nx   = ge ? rem_sub[DIG_W-1:0] : rem_sh[DIG_W-1:0];
    assign quo_nx   = {r_quo[ACC_W-2:0], ge};
    assign bit_done = (r_bit == BIT_CNT_W'(ACC_W - 1));
    assign div_done = bit_done && (r_dcnt == CNT_W'(DIGIT_COUNT - 1));

    assign emit_take = (r_state == ST_EMIT) && i_m_tready;
    assign emit_done = emit_take && (r_idx == CNT_W'(DIGIT_COUNT - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop      = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: o_pop      = !i_empty;
            ST_EMIT: o_m_tvalid = 1'b1;
            default: ;
        endcase
        o_m_tdata = {{(TDATA_W-DIG_W){1'b0}}, r_digs[r_idx]};
        o_m_tlast = (r_idx == CNT_W'(DIGIT_COUNT - 1));
        o_m_tuser = r_ovf;
    end

    // datapath next values
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_bit  = r_bit;
        n_dcnt = r_dcnt;
        n_idx  = r_idx;
        n_ovf  = r_ovf;
        case (r_state)
            ST_IDLE: begin
                n_quo  = i_req.value;
                n_div  = i_req.base;
                n_rem  = '0;
                n_bit  = '0;
                n_dcnt = '0;
                n_idx  = '0;
            end
            ST_DIV: begin
                n_quo = quo_nx;
                if (bit_done) begin
                    n_rem  = '0;
                    n_bit  = '0;
                    n_dcnt = r_dcnt + 1'b1;
                    n_ovf  = (quo_nx != '0);
                end else begin
                    n_rem = rem_nx;
                    n_bit = r_bit + 1'b1;
                end
            end
            ST_EMIT: begin
                if (emit_done) begin
                    n_idx = '0;
                end else if (emit_take) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // digits land least significant first, at the far end of the row
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && bit_done) begin
            r_digs[CNT_W'(DIGIT_COUNT - 1) - r_dcnt] <= rem_nx;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_bit  <= n_bit;
        r_dcnt <= n_dcnt;
        r_ovf  <= n_ovf;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== design/integer_radix_converter.sv =====
// Fixed-length radix converter: numbers of ten digit values arrive most
// significant digit first, in the configured base (direction 0) or in
// decimal (direction 1), and leave as ten digits in the other base, most
// significant first, with tlast on the final digit and tuser set on every
// digit when nonzero high digits were dropped. The front takes one digit
// per cycle, except that a number's last digit waits while the queue is
// full, and folds it into a 40-bit accumulator; a finished number moves
// through a two-entry queue to the back, whose bit-serial divider produces
// the ten output digits one after another. The back works on one number
// at a time and pops the next only after the last digit of the current
// one has been sent; the front keeps taking digits meanwhile.
module integer_radix_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: index 0 direction, index 1 radix
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [4:0] i_cfg_wdata,
    // digit requests in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] digit_in, [7:4] zero
    // converted digits out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] digit_out, [7:4] zero
    output logic       m_axis_tlast,   // last_digit
    output logic       m_axis_tuser    // [0] overflow
);
    import irc_pkg::*;

    t_conv_req push_req;
    t_conv_req pop_req;
    logic      push;
    logic      full;
    logic      pop;
    logic      empty;

    // front: horner accumulation
    irc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tdata   (s_axis_tdata[3:0]),
        .o_s_tready  (s_axis_tready),
        .i_full      (full),
        .o_push      (push),
        .o_req       (push_req)
    );

    // queue of finished numbers
    irc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_req   (pop_req)
    );

    // back: repeated division and digit output
    irc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_req      (pop_req),
        .o_pop      (pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule
